@@ sv/polygon_point_and_ray_test_core_assert.svh @@
// assertion macros used by the checker
`ifndef POLYGON_POINT_AND_RAY_TEST_CORE_ASSERT_SVH
`define POLYGON_POINT_AND_RAY_TEST_CORE_ASSERT_SVH

// same-cycle implication, off while reset is high
`define PIT_ASSERT_IMP(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define PIT_ASSERT_NXT(label, rst, ante, cons) \
   label: assert property (@(posedge clock) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

@@ sv/pit_pkg.sv @@
package pit_pkg;

   localparam int MAX_CORNERS = 8;
   localparam int FRAC_BITS   = 16;
   localparam int COORD_W     = 32;
   localparam int IDX_W       = $clog2(MAX_CORNERS);
   localparam int CNT_W       = $clog2(MAX_CORNERS + 1);

   // scaled ray component, its length and the shared multiplier widths
   localparam int QX_W   = 2 * COORD_W - FRAC_BITS;
   localparam int ROOT_W = QX_W + 1;
   localparam int MAG_W  = ROOT_W;
   localparam int OP_W   = MAG_W + 1;
   localparam int PROD_W = 2 * OP_W;
   localparam int SQ_W   = 2 * ROOT_W;
   localparam int REM_W  = ROOT_W + 3;
   localparam int QUO_W  = FRAC_BITS + 1;
   localparam int STEP_W = $clog2(MAG_W + 1);

   localparam int REQ_W = 136;
   localparam int RSP_W = 40;

   typedef enum logic [1:0] {
      REG_CENTER_X     = 2'd0,
      REG_CENTER_Y     = 2'd1,
      REG_RAY_LENGTH   = 2'd2,
      REG_CORNER_COUNT = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_INSIDE = 2'd1,
      CMD_RAY    = 2'd2,
      CMD_NONE   = 2'd3
   } cmd_type;

   typedef enum logic [3:0] {
      OP_QX     = 4'd0,
      OP_QY     = 4'd1,
      OP_SQX    = 4'd2,
      OP_SQY    = 4'd3,
      OP_SXEY   = 4'd4,
      OP_SYEX   = 4'd5,
      OP_AXEY   = 4'd6,
      OP_AYEX   = 4'd7,
      OP_AXSY   = 4'd8,
      OP_AYSX   = 4'd9,
      OP_DIST   = 4'd10
   } op_type;

   typedef enum logic [11:0] {
      S_IDLE     = 12'b0000_0000_0001,
      S_MUL_GO   = 12'b0000_0000_0010,
      S_MUL_WAIT = 12'b0000_0000_0100,
      S_SQRT     = 12'b0000_0000_1000,
      S_RD0      = 12'b0000_0001_0000,
      S_RD0W     = 12'b0000_0010_0000,
      S_RDN      = 12'b0000_0100_0000,
      S_RDNW     = 12'b0000_1000_0000,
      S_CMP      = 12'b0001_0000_0000,
      S_DIV      = 12'b0010_0000_0000,
      S_NEXT     = 12'b0100_0000_0000,
      S_OUT      = 12'b1000_0000_0000
   } state_type;

   typedef struct packed {
      logic                   start;
      logic signed [OP_W-1:0] a;
      logic signed [OP_W-1:0] b;
   } mul_req_type;

endpackage

@@ sv/pit_ram.sv @@
module pit_ram #(
   parameter int WIDTH  = 64,
   parameter int DEPTH  = 8,
   parameter int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ sv/pit_mul.sv @@
module pit_mul (
   input  logic                                 clock,
   input  logic                                 reset,
   input  pit_pkg::mul_req_type                 mul_req,
   output logic                                 mul_done,
   output logic signed [pit_pkg::PROD_W-1:0]    mul_prod
);
   import pit_pkg::*;

   logic [MAG_W-1:0]  acc_ff, acc_in;
   logic [MAG_W-1:0]  mlr_ff, mlr_in;
   logic [MAG_W-1:0]  mcd_ff, mcd_in;
   logic              neg_ff, neg_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [OP_W-1:0]   a_abs, b_abs;
   logic [MAG_W:0]    sum;
   logic [PROD_W-1:0] mag;

   assign a_abs = mul_req.a[OP_W-1] ? OP_W'(-mul_req.a) : OP_W'(mul_req.a);
   assign b_abs = mul_req.b[OP_W-1] ? OP_W'(-mul_req.b) : OP_W'(mul_req.b);
   assign sum   = {1'b0, acc_ff} + {1'b0, (mlr_ff[0] ? mcd_ff : {MAG_W{1'b0}})};

   always_comb begin
      acc_in  = acc_ff;
      mlr_in  = mlr_ff;
      mcd_in  = mcd_ff;
      neg_in  = neg_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (mul_req.start) begin
         acc_in  = '0;
         mlr_in  = b_abs[MAG_W-1:0];
         mcd_in  = a_abs[MAG_W-1:0];
         neg_in  = mul_req.a[OP_W-1] ^ mul_req.b[OP_W-1];
         cnt_in  = STEP_W'(MAG_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // shift-add, one multiplier bit per cycle
         acc_in = sum[MAG_W:1];
         mlr_in = {sum[0], mlr_ff[MAG_W-1:1]};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      acc_ff <= acc_in;
      mlr_ff <= mlr_in;
      mcd_ff <= mcd_in;
      neg_ff <= neg_in;
   end

   assign mag      = {2'b00, acc_ff, mlr_ff};
   assign mul_prod = neg_ff ? -$signed(mag) : $signed(mag);
   assign mul_done = done_ff;

endmodule

@@ sv/polygon_point_and_ray_test_core.sv @@
// Polygon point-and-ray test core.
// Request channel (req_*): one request per handshake. A load request writes one
// polygon corner and gives no response; an inside request tests the point
// against every edge; a ray request measures the distance to the nearer of the first two hits.
// Response channel (rsp_*): one response per inside or ray request.
// Control port (csr_*): center, ray length and corner count, written while idle.
// All products come from one shared shift-add multiplier under a small
// sequencer; a square root and a quotient are iterated bit by bit in the
// sequencer's own registers.
// One request is worked at a time; req_tready is high only when idle.
// The response sits in an output register, so the next request is taken while
// it waits; a stalled receiver holds the block before it writes the next one.
// Reset clears the sequencer and the response valid and restores the control
// registers; corner contents stay undefined until loaded.
module polygon_point_and_ray_test_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // cmd, corner_index, pos_x, pos_y, dir_x, dir_y
   input  logic [pit_pkg::REQ_W-1:0]     req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // inside_res, level_value, distance, hits
   output logic [pit_pkg::RSP_W-1:0]     rsp_tdata,
   input  logic                          csr_we,
   input  logic [1:0]                    csr_addr,
   input  logic [31:0]                   csr_wdata
);
   import pit_pkg::*;

   state_type                  state_ff, state_in;
   op_type                     op_ff, op_in;
   cmd_type                    cmd_ff, cmd_in;
   logic signed [COORD_W-1:0]  px_ff, px_in, py_ff, py_in;
   logic [COORD_W-1:0]         dxm_ff, dxm_in, dym_ff, dym_in;
   logic                       dxs_ff, dxs_in, dys_ff, dys_in;
   logic [QX_W-1:0]            qx_ff, qx_in, qy_ff, qy_in;
   logic [SQ_W-1:0]            sq_ff, sq_in;
   logic [REM_W-1:0]           rem_ff, rem_in;
   logic [ROOT_W-1:0]          root_ff, root_in;
   logic [STEP_W-1:0]          step_ff, step_in;
   logic signed [OP_W-1:0]     sx_ff, sx_in, sy_ff, sy_in;
   logic signed [COORD_W-1:0]  curx_ff, curx_in, cury_ff, cury_in;
   logic signed [COORD_W-1:0]  nxtx_ff, nxtx_in, nxty_ff, nxty_in;
   logic signed [COORD_W:0]    ax_ff, ax_in, ay_ff, ay_in, ex_ff, ex_in, ey_ff, ey_in;
   logic signed [PROD_W-1:0]   d_ff, d_in, t_ff, t_in, u_ff, u_in;
   logic [QUO_W-1:0]           q_ff, q_in;
   logic [CNT_W-1:0]           idx_ff, idx_in;
   logic [3:0]                 hits_ff, hits_in;
   logic [31:0]                dist_ff, dist_in;
   logic signed [COORD_W-1:0]  cx_ff, cy_ff;
   logic [31:0]                rl_ff;
   logic [3:0]                 cc_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]           rsp_data_ff, rsp_data_in;

   logic                       req_fire;
   logic [1:0]                 f_cmd;
   logic [2:0]                 f_idx;
   logic signed [COORD_W-1:0]  f_px, f_py, f_dx, f_dy;
   logic [CNT_W-1:0]           n_cnt, idx_nxt;
   logic                       ram_we;
   logic [IDX_W-1:0]           ram_raddr;
   logic [2*COORD_W-1:0]       ram_rdata;
   mul_req_type                mul_req;
   logic                       mul_done;
   logic signed [PROD_W-1:0]   mul_prod;
   logic [ROOT_W+1:0]          sq_trial;
   logic [REM_W-1:0]           rem_sh;
   logic signed [PROD_W-1:0]   d2, t2, u2;
   logic                       hit;
   logic [31:0]                dist_v;
   logic signed [COORD_W:0]    rx, ry;

   function automatic logic signed [OP_W-1:0] sx33(input logic signed [COORD_W:0] v);
      sx33 = {{(OP_W-COORD_W-1){v[COORD_W]}}, v};
   endfunction

   assign req_tready = (state_ff == S_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign f_cmd = req_tdata[1:0];
   assign f_idx = req_tdata[4:2];
   assign f_px  = req_tdata[36:5];
   assign f_py  = req_tdata[68:37];
   assign f_dx  = req_tdata[100:69];
   assign f_dy  = req_tdata[132:101];

   assign n_cnt   = (cc_ff > 4'(MAX_CORNERS)) ? CNT_W'(MAX_CORNERS) : CNT_W'(cc_ff);
   assign idx_nxt = idx_ff + 1'b1;
   assign ram_we  = req_fire && (cmd_type'(f_cmd) == CMD_LOAD)
                    && (32'(f_idx) < 32'(MAX_CORNERS));

   always_comb begin
      ram_raddr = '0;
      if (state_ff == S_RDN && idx_nxt < n_cnt) begin
         ram_raddr = idx_nxt[IDX_W-1:0];
      end
   end

   pit_ram #(.WIDTH(2 * COORD_W), .DEPTH(MAX_CORNERS)) u_corners (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (IDX_W'(f_idx)),
      .wr_data ({f_py, f_px}),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // operand select for the shared multiplier
   always_comb begin
      mul_req.start = (state_ff == S_MUL_GO);
      mul_req.a     = '0;
      mul_req.b     = '0;
      unique case (op_ff)
         OP_QX: begin
            mul_req.a = {{(OP_W-COORD_W){1'b0}}, rl_ff};
            mul_req.b = {{(OP_W-COORD_W){1'b0}}, dxm_ff};
         end
         OP_QY: begin
            mul_req.a = {{(OP_W-COORD_W){1'b0}}, rl_ff};
            mul_req.b = {{(OP_W-COORD_W){1'b0}}, dym_ff};
         end
         OP_SQX: begin
            mul_req.a = {{(OP_W-QX_W){1'b0}}, qx_ff};
            mul_req.b = {{(OP_W-QX_W){1'b0}}, qx_ff};
         end
         OP_SQY: begin
            mul_req.a = {{(OP_W-QX_W){1'b0}}, qy_ff};
            mul_req.b = {{(OP_W-QX_W){1'b0}}, qy_ff};
         end
         OP_SXEY: begin
            mul_req.a = sx_ff;
            mul_req.b = sx33(ey_ff);
         end
         OP_SYEX: begin
            mul_req.a = sy_ff;
            mul_req.b = sx33(ex_ff);
         end
         OP_AXEY: begin
            mul_req.a = sx33(ax_ff);
            mul_req.b = sx33(ey_ff);
         end
         OP_AYEX: begin
            mul_req.a = sx33(ay_ff);
            mul_req.b = sx33(ex_ff);
         end
         OP_AXSY: begin
            mul_req.a = sx33(ax_ff);
            mul_req.b = sy_ff;
         end
         OP_AYSX: begin
            mul_req.a = sx33(ay_ff);
            mul_req.b = sx_ff;
         end
         OP_DIST: begin
            mul_req.a = {{(OP_W-ROOT_W){1'b0}}, root_ff};
            mul_req.b = {{(OP_W-QUO_W){1'b0}}, q_ff};
         end
         default: begin
            mul_req.a = '0;
            mul_req.b = '0;
         end
      endcase
   end

   pit_mul u_mul (
      .clock    (clock),
      .reset    (reset),
      .mul_req  (mul_req),
      .mul_done (mul_done),
      .mul_prod (mul_prod)
   );

   assign sq_trial = {root_ff, 2'b01};
   assign rem_sh   = {rem_ff[REM_W-3:0], sq_ff[SQ_W-1 -: 2]};
   assign d2  = d_ff[PROD_W-1] ? -d_ff : d_ff;
   assign t2  = d_ff[PROD_W-1] ? -t_ff : t_ff;
   assign u2  = d_ff[PROD_W-1] ? -u_ff : u_ff;
   assign hit = (d_ff != '0) && !t2[PROD_W-1] && !(d2 < t2) && !u2[PROD_W-1] && !(d2 < u2);
   assign dist_v = (mul_prod[PROD_W-1:FRAC_BITS+32] != '0) ? 32'hFFFF_FFFF
                   : mul_prod[FRAC_BITS+31:FRAC_BITS];
   assign rx = {ram_rdata[COORD_W-1], ram_rdata[COORD_W-1:0]};
   assign ry = {ram_rdata[2*COORD_W-1], ram_rdata[2*COORD_W-1:COORD_W]};

   always_comb begin
      state_in = state_ff;
      op_in    = op_ff;
      cmd_in   = cmd_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      dxm_in   = dxm_ff;
      dym_in   = dym_ff;
      dxs_in   = dxs_ff;
      dys_in   = dys_ff;
      qx_in    = qx_ff;
      qy_in    = qy_ff;
      sq_in    = sq_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      step_in  = step_ff;
      sx_in    = sx_ff;
      sy_in    = sy_ff;
      curx_in  = curx_ff;
      cury_in  = cury_ff;
      nxtx_in  = nxtx_ff;
      nxty_in  = nxty_ff;
      ax_in    = ax_ff;
      ay_in    = ay_ff;
      ex_in    = ex_ff;
      ey_in    = ey_ff;
      d_in     = d_ff;
      t_in     = t_ff;
      u_in     = u_ff;
      q_in     = q_ff;
      idx_in   = idx_ff;
      hits_in  = hits_ff;
      dist_in  = dist_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               cmd_in  = cmd_type'(f_cmd);
               px_in   = f_px;
               py_in   = f_py;
               dxs_in  = f_dx[COORD_W-1];
               dys_in  = f_dy[COORD_W-1];
               dxm_in  = f_dx[COORD_W-1] ? -f_dx : f_dx;
               dym_in  = f_dy[COORD_W-1] ? -f_dy : f_dy;
               idx_in  = '0;
               hits_in = '0;
               dist_in = '0;
               sx_in   = sx33({f_px[COORD_W-1], f_px} - {cx_ff[COORD_W-1], cx_ff});
               sy_in   = sx33({f_py[COORD_W-1], f_py} - {cy_ff[COORD_W-1], cy_ff});
               unique case (cmd_type'(f_cmd))
                  CMD_INSIDE: state_in = (n_cnt == '0) ? S_OUT : S_RD0;
                  CMD_RAY: begin
                     op_in    = OP_QX;
                     state_in = S_MUL_GO;
                  end
                  CMD_LOAD, CMD_NONE: state_in = S_IDLE;
               endcase
            end
         end
         S_MUL_GO: state_in = S_MUL_WAIT;
         S_MUL_WAIT: begin
            if (mul_done) begin
               state_in = S_MUL_GO;
               unique case (op_ff)
                  OP_QX: begin
                     qx_in = mul_prod[QX_W+FRAC_BITS-1:FRAC_BITS];
                     op_in = OP_QY;
                  end
                  OP_QY: begin
                     qy_in = mul_prod[QX_W+FRAC_BITS-1:FRAC_BITS];
                     // segment runs from origin to origin plus the scaled direction
                     sx_in = dxs_ff ? {{(OP_W-QX_W){1'b0}}, qx_ff}
                                    : -{{(OP_W-QX_W){1'b0}}, qx_ff};
                     sy_in = dys_ff ? {{(OP_W-QX_W){1'b0}},
                                       mul_prod[QX_W+FRAC_BITS-1:FRAC_BITS]}
                                    : -{{(OP_W-QX_W){1'b0}},
                                        mul_prod[QX_W+FRAC_BITS-1:FRAC_BITS]};
                     op_in = OP_SQX;
                  end
                  OP_SQX: begin
                     sq_in = mul_prod[SQ_W-1:0];
                     op_in = OP_SQY;
                  end
                  OP_SQY: begin
                     sq_in    = sq_ff + mul_prod[SQ_W-1:0];
                     rem_in   = '0;
                     root_in  = '0;
                     step_in  = STEP_W'(ROOT_W);
                     state_in = S_SQRT;
                  end
                  OP_SXEY: begin
                     d_in  = mul_prod;
                     op_in = OP_SYEX;
                  end
                  OP_SYEX: begin
                     d_in  = d_ff - mul_prod;
                     op_in = OP_AXEY;
                  end
                  OP_AXEY: begin
                     t_in  = mul_prod;
                     op_in = OP_AYEX;
                  end
                  OP_AYEX: begin
                     t_in  = t_ff - mul_prod;
                     op_in = OP_AXSY;
                  end
                  OP_AXSY: begin
                     u_in  = mul_prod;
                     op_in = OP_AYSX;
                  end
                  OP_AYSX: begin
                     u_in     = u_ff - mul_prod;
                     state_in = S_CMP;
                  end
                  OP_DIST: begin
                     if (hits_ff == 4'd1 || dist_v < dist_ff) begin
                        dist_in = dist_v;
                     end
                     state_in = S_NEXT;
                  end
                  default: state_in = S_IDLE;
               endcase
            end
         end
         S_SQRT: begin
            // one root bit per cycle from the top pair of the radicand
            sq_in   = sq_ff << 2;
            step_in = step_ff - 1'b1;
            if (rem_sh >= REM_W'(sq_trial)) begin
               rem_in  = rem_sh - REM_W'(sq_trial);
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            if (step_ff == STEP_W'(1)) begin
               state_in = (n_cnt == '0) ? S_OUT : S_RD0;
            end
         end
         S_RD0: state_in = S_RD0W;
         S_RD0W: begin
            curx_in  = ram_rdata[COORD_W-1:0];
            cury_in  = ram_rdata[2*COORD_W-1:COORD_W];
            state_in = S_RDN;
         end
         S_RDN: state_in = S_RDNW;
         S_RDNW: begin
            nxtx_in  = ram_rdata[COORD_W-1:0];
            nxty_in  = ram_rdata[2*COORD_W-1:COORD_W];
            ax_in    = {px_ff[COORD_W-1], px_ff} - {curx_ff[COORD_W-1], curx_ff};
            ay_in    = {py_ff[COORD_W-1], py_ff} - {cury_ff[COORD_W-1], cury_ff};
            ex_in    = {curx_ff[COORD_W-1], curx_ff} - rx;
            ey_in    = {cury_ff[COORD_W-1], cury_ff} - ry;
            op_in    = OP_SXEY;
            state_in = S_MUL_GO;
         end
         S_CMP: begin
            // normalize to a positive denominator
            d_in     = d2;
            t_in     = t2;
            u_in     = u2;
            state_in = S_NEXT;
            if (hit) begin
               hits_in = hits_ff + 1'b1;
               if (cmd_ff == CMD_RAY && hits_ff < 4'd2) begin
                  q_in     = '0;
                  step_in  = STEP_W'(QUO_W);
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            // restoring division, one quotient bit per cycle
            step_in = step_ff - 1'b1;
            if ($unsigned(t_ff) >= $unsigned(d_ff)) begin
               t_in = (t_ff - d_ff) <<< 1;
               q_in = {q_ff[QUO_W-2:0], 1'b1};
            end else begin
               t_in = t_ff <<< 1;
               q_in = {q_ff[QUO_W-2:0], 1'b0};
            end
            if (step_ff == STEP_W'(1)) begin
               op_in    = OP_DIST;
               state_in = S_MUL_GO;
            end
         end
         S_NEXT: begin
            curx_in  = nxtx_ff;
            cury_in  = nxty_ff;
            idx_in   = idx_nxt;
            state_in = (idx_nxt == n_cnt) ? S_OUT : S_RDN;
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               if (cmd_ff == CMD_INSIDE) begin
                  rsp_data_in = {1'b0, hits_ff, 32'd0,
                                 (hits_ff == '0) ? 2'b11 : 2'b01, hits_ff == '0};
               end else begin
                  rsp_data_in = {1'b0, hits_ff,
                                 (hits_ff == 4'd1 || hits_ff == 4'd2) ? dist_ff : 32'd0,
                                 2'b00, 1'b0};
               end
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         op_ff        <= OP_QX;
         rsp_valid_ff <= 1'b0;
         cx_ff        <= '0;
         cy_ff        <= '0;
         rl_ff        <= 32'd65536;
         cc_ff        <= 4'd4;
      end else begin
         state_ff     <= state_in;
         op_ff        <= op_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_addr))
               REG_CENTER_X:     cx_ff <= csr_wdata;
               REG_CENTER_Y:     cy_ff <= csr_wdata;
               REG_RAY_LENGTH:   rl_ff <= csr_wdata;
               REG_CORNER_COUNT: cc_ff <= csr_wdata[3:0];
            endcase
         end
      end
      cmd_ff      <= cmd_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      dxm_ff      <= dxm_in;
      dym_ff      <= dym_in;
      dxs_ff      <= dxs_in;
      dys_ff      <= dys_in;
      qx_ff       <= qx_in;
      qy_ff       <= qy_in;
      sq_ff       <= sq_in;
      rem_ff      <= rem_in;
      root_ff     <= root_in;
      step_ff     <= step_in;
      sx_ff       <= sx_in;
      sy_ff       <= sy_in;
      curx_ff     <= curx_in;
      cury_ff     <= cury_in;
      nxtx_ff     <= nxtx_in;
      nxty_ff     <= nxty_in;
      ax_ff       <= ax_in;
      ay_ff       <= ay_in;
      ex_ff       <= ex_in;
      ey_ff       <= ey_in;
      d_ff        <= d_in;
      t_ff        <= t_in;
      u_ff        <= u_in;
      q_ff        <= q_in;
      idx_ff      <= idx_in;
      hits_ff     <= hits_in;
      dist_ff     <= dist_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

@@ sv/pit_checker.sv @@
`include "polygon_point_and_ray_test_core_assert.svh"

module pit_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_tvalid,
   input logic                      req_tready,
   input logic [pit_pkg::REQ_W-1:0] req_tdata,
   input logic                      rsp_tvalid,
   input logic                      rsp_tready,
   input logic [pit_pkg::RSP_W-1:0] rsp_tdata,
   input logic                      csr_we,
   input logic [1:0]                csr_addr,
   input logic [31:0]               csr_wdata
);
   import pit_pkg::*;

   logic query_fire;
   logic cfg_seen;

   assign query_fire = req_tvalid && req_tready
                       && (req_tdata[1:0] == CMD_INSIDE || req_tdata[1:0] == CMD_RAY);
   assign cfg_seen   = csr_we && (csr_addr == REG_CENTER_X || csr_addr != REG_CENTER_X)
                       && (csr_wdata == csr_wdata);

   // a stalled response holds
   `PIT_ASSERT_NXT(a_rsp_hold, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata))
   // a query keeps the block busy the next cycle
   `PIT_ASSERT_NXT(a_query_busy, reset, query_fire && !cfg_seen, !req_tready)
   // an inside response carries level -1, no distance and no hits
   `PIT_ASSERT_IMP(a_inside_fields, reset, rsp_tvalid && rsp_tdata[0],
      rsp_tdata[2:1] == 2'b11 && rsp_tdata[34:3] == 32'd0 && rsp_tdata[38:35] == 4'd0)
   // an outside response counts at least one crossing
   `PIT_ASSERT_IMP(a_outside_hits, reset, rsp_tvalid && rsp_tdata[2:1] == 2'b01,
      rsp_tdata[38:35] != 4'd0 && !rsp_tdata[0])

endmodule

bind polygon_point_and_ray_test_core pit_checker u_pit_checker (.*);
